@@ rtl/ccpr_pkg.sv @@
// Shared types and constants for the character cell pixel renderer.
package ccpr_pkg;

   localparam int unsigned LINE_PIXELS_DEFAULT = 320;
   localparam int unsigned CELL_PIXELS         = 8;
   localparam int unsigned OFFSET_W            = 16;
   localparam int unsigned COLOR_W             = 4;
   localparam int unsigned MODE_W              = 2;
   localparam int unsigned CSR_INDEX_W         = 2;
   localparam int unsigned CSR_DATA_W          = 4;

   // Display modes; the unused code renders as multicolour.
   localparam logic [MODE_W-1:0] MODE_TEXT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BITMAP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MULTI  = 2'd2;

   // Register indexes on the csr channel.
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_MODE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND_COLOR = 2'd1;

   // Multicolour pixel pair codes.
   localparam logic [1:0] PAIR_BACKGROUND = 2'b00;
   localparam logic [1:0] PAIR_SCREEN_HI  = 2'b01;
   localparam logic [1:0] PAIR_SCREEN_LO  = 2'b10;
   localparam logic [1:0] PAIR_COLOR_RAM  = 2'b11;

   typedef struct packed {
      logic [5:0] cell_column;
      logic [4:0] cell_row;
      logic [2:0] cell_line;
      logic [7:0] pattern_byte;
      logic [7:0] screen_byte;
      logic [3:0] color_nibble;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_offset;
      logic [3:0]  pixel_0;
      logic [3:0]  pixel_1;
      logic [3:0]  pixel_2;
      logic [3:0]  pixel_3;
      logic [3:0]  pixel_4;
      logic [3:0]  pixel_5;
      logic [3:0]  pixel_6;
      logic [3:0]  pixel_7;
   } rsp_type;

endpackage

@@ rtl/char_cell_pixel_renderer_unit.sv @@
// Top level of the character cell pixel renderer.
//
// Usage:
//   The req channel carries one transaction per 8-pixel line of a character
//   cell: cell position, line within the cell, pattern byte, screen byte and
//   color RAM nibble. The rsp channel returns the frame buffer offset of the
//   line's leftmost pixel and eight 4-bit palette indices, left to right.
//   The csr channel writes display_mode (index 0) and background_color
//   (index 1); csr_ready is always high, other indexes are dropped.
//   Write csr only while no transaction is in flight.
// Timing:
//   Two stages: an input register and a result register, with the decode
//   and offset multiply between them. An accepted req is held in the input
//   register, then in the result register; one/cycle while rsp_stall is low.
// Reset:
//   Synchronous, active high. Both stages empty, display_mode = text,
//   background_color = 0.
// Backpressure:
//   While rsp_stall is high a full result register holds. The input register
//   still fills, and req_stall rises only when both stages are full.
module char_cell_pixel_renderer_unit
   import ccpr_pkg::*;
#(
   parameter int unsigned LINE_PIXELS = LINE_PIXELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // configuration channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic [OFFSET_W-1:0] LINE_PIXELS_W = OFFSET_W'(LINE_PIXELS);

   // configuration registers
   logic [MODE_W-1:0]  display_mode_ff, display_mode_in;
   logic [COLOR_W-1:0] background_ff, background_in;

   // stage 1: input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;

   // stage 2: result register
   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_data_ff, s2_data_in;

   logic s1_advance;
   logic s2_advance;

   // decode signals
   logic [7:0]          row_line;
   logic [OFFSET_W-1:0] line_base;
   logic [OFFSET_W-1:0] column_base;
   logic [COLOR_W-1:0]  screen_hi;
   logic [COLOR_W-1:0]  screen_lo;
   logic [COLOR_W-1:0]  set_color;
   logic [COLOR_W-1:0]  clear_color;
   logic [1:0]          pair;
   logic [COLOR_W-1:0]  pixels [CELL_PIXELS];

   // ---------------------------------------------------------------
   // Handshake: the result register advances when empty or drained,
   // the input register advances when empty or whenever the result register does.
   // ---------------------------------------------------------------
   assign s2_advance = !s2_valid_ff || !rsp_stall;
   assign s1_advance = !s1_valid_ff || s2_advance;
   assign req_stall  = !s1_advance;
   assign rsp_valid  = s2_valid_ff;
   assign rsp_data   = s2_data_ff;
   assign csr_ready  = 1'b1;

   assign s1_valid_in = s1_advance ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_advance ? s1_valid_ff : s2_valid_ff;

   // ---------------------------------------------------------------
   // Register writes; unknown indexes are dropped.
   // ---------------------------------------------------------------
   always_comb begin
      display_mode_in = display_mode_ff;
      background_in   = background_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DISPLAY_MODE:     display_mode_in = csr_data[MODE_W-1:0];
            CSR_BACKGROUND_COLOR: background_in   = csr_data[COLOR_W-1:0];
            default:              ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Offset: (row*8 + line) * LINE_PIXELS + column*8, wrapped to 16 bits.
   // ---------------------------------------------------------------
   assign row_line    = {s1_data_ff.cell_row, s1_data_ff.cell_line};
   assign line_base   = OFFSET_W'(OFFSET_W'(row_line) * LINE_PIXELS_W);
   assign column_base = OFFSET_W'({s1_data_ff.cell_column, 3'b000});

   // ---------------------------------------------------------------
   // Pixel decode
   // ---------------------------------------------------------------
   assign screen_hi = s1_data_ff.screen_byte[7:4];
   assign screen_lo = s1_data_ff.screen_byte[3:0];

   always_comb begin
      pair        = PAIR_BACKGROUND;
      set_color   = s1_data_ff.color_nibble;
      clear_color = background_ff;
      case (display_mode_ff)
         MODE_TEXT: begin
            set_color   = s1_data_ff.color_nibble;
            clear_color = background_ff;
         end
         MODE_BITMAP: begin
            set_color   = screen_hi;
            clear_color = screen_lo;
         end
         default: begin
            set_color   = s1_data_ff.color_nibble;
            clear_color = background_ff;
         end
      endcase
      for (int i = 0; i < CELL_PIXELS; i++) begin
         // bit 7 is the leftmost pixel
         if (display_mode_ff[1]) begin
            pair = s1_data_ff.pattern_byte[7 - (i / 2) * 2 -: 2];
            case (pair)
               PAIR_BACKGROUND: pixels[i] = background_ff;
               PAIR_SCREEN_HI:  pixels[i] = screen_hi;
               PAIR_SCREEN_LO:  pixels[i] = screen_lo;
               default:         pixels[i] = s1_data_ff.color_nibble;
            endcase
         end else begin
            pixels[i] = s1_data_ff.pattern_byte[7 - i] ? set_color : clear_color;
         end
      end
   end

   always_comb begin
      s2_data_in.pixel_offset = line_base + column_base;
      s2_data_in.pixel_0      = pixels[0];
      s2_data_in.pixel_1      = pixels[1];
      s2_data_in.pixel_2      = pixels[2];
      s2_data_in.pixel_3      = pixels[3];
      s2_data_in.pixel_4      = pixels[4];
      s2_data_in.pixel_5      = pixels[5];
      s2_data_in.pixel_6      = pixels[6];
      s2_data_in.pixel_7      = pixels[7];
   end

   // ---------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         display_mode_ff <= MODE_TEXT;
         background_ff   <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         display_mode_ff <= display_mode_in;
         background_ff   <= background_in;
      end
   end

   // Payload: load on advance, hold otherwise.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_data_ff <= req_data;
      end
      if (s2_advance) begin
         s2_data_ff <= s2_data_in;
      end
   end

endmodule

@@ rtl/ccpr_checker.sv @@
// Port-level assertions for the character cell pixel renderer, bound to the top.
module ccpr_checker
   import ccpr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Both stages come out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Input backpressure only comes from a full, stalled output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without output backpressure");

   // An accepted transaction reaches the result register when the output drains.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing after two cycles");

endmodule

bind char_cell_pixel_renderer_unit ccpr_checker u_ccpr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
